// ===== rtl/ggc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggc_pkg
// shared constants and types of the greedy graph coloring engine
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_EDGES    = 8192;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IDX_W   = 14;
  localparam int unsigned VAL_W   = 14;
  localparam int unsigned COLOR_W = 11;
  localparam int unsigned CFG_W   = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_ROW_START = 0,
    CMD_NEIGHBOR  = 1,
    CMD_CLEAR     = 2,
    CMD_COLOR     = 3,
    CMD_CHECK     = 4,
    CMD_READ      = 5
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW0,
    S_ROW1,
    S_ROW2,
    S_WALK_SET,
    S_SEARCH,
    S_WALK_CLR,
    S_WALK_CHK,
    S_RESP
  } state_e;

endpackage

// ===== rtl/ggc_if.sv =====
// ----------------------------------------------------------------------------
// ggc channel interfaces
// command, result and configuration channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface ggc_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [ggc_pkg::CMD_W-1:0]   command;
  logic [ggc_pkg::IDX_W-1:0]   index;
  logic [ggc_pkg::VAL_W-1:0]   value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

interface ggc_res_if;
  logic                        valid;
  logic                        ready;
  logic [ggc_pkg::COLOR_W-1:0] color;
  logic                        conflict;

  modport source (output valid, color, conflict, input ready);
  modport sink   (input valid, color, conflict, output ready);
endinterface

interface ggc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ggc_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/greedy_graph_coloring.sv =====
// ----------------------------------------------------------------------------
// greedy_graph_coloring
// first-fit coloring of a graph held in compressed row form
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// cfg_i    in   valid/ready   data (vertex count)
// cmd_i    in   valid/ready   command, index, value
// res_o    out  valid/ready   color, conflict
//
// color and check run times are set by the edge walk through the neighbor ram
// and the one read port of the color ram.
// clear colors sweeps the color and mark rams.
// after reset the color and mark rams are swept and
// cmd_i is not ready meanwhile; cfg_i is always ready.
// a result waits in the output register; the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module greedy_graph_coloring #(
  parameter int unsigned MaxVertices = ggc_pkg::MAX_VERTICES,
  parameter int unsigned MaxEdges    = ggc_pkg::MAX_EDGES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ggc_cfg_if.sink    cfg_i,
  ggc_cmd_if.sink    cmd_i,
  ggc_res_if.source  res_o
);

  import ggc_pkg::*;

  localparam int unsigned VAW = $clog2(MaxVertices + 1);
  localparam int unsigned RAW = $clog2(MaxVertices + 2);
  localparam int unsigned EAW = $clog2(MaxEdges);

  state_e state_q, state_d;

  // control
  logic            init_q, init_d;
  logic            ov_q, ov_d;
  logic [VAW-1:0]  vc_q;
  logic            p1_q, p1_d;
  logic            p2_q, p2_d;
  logic            sp_q, sp_d;
  logic [VAW-1:0]  clr_q, clr_d;

  // datapath
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [VAW-1:0]     vtx_q, vtx_d;
  logic [VAL_W-1:0]   lo_q, lo_d;
  logic [VAL_W-1:0]   hi_q, hi_d;
  logic [VAL_W-1:0]   slot_q, slot_d;
  logic [VAW-1:0]     cv_q, cv_d;
  logic [VAW-1:0]     res_col_q, res_col_d;
  logic               conf_q, conf_d;
  logic [RAW-1:0]     srch_q, srch_d;
  logic [RAW-1:0]     sc_q, sc_d;
  logic [COLOR_W-1:0] out_col_q, out_col_d;
  logic               out_conf_q, out_conf_d;

  // ram ports
  logic             row_we;
  logic [RAW-1:0]   row_waddr, row_raddr;
  logic [VAL_W-1:0] row_wdata, row_rdata;
  logic             nbr_we;
  logic [EAW-1:0]   nbr_waddr, nbr_raddr;
  logic [VAW-1:0]   nbr_wdata, nbr_rdata;
  logic             col_we;
  logic [VAW-1:0]   col_waddr, col_raddr, col_wdata, col_rdata;
  logic             mark_we;
  logic [VAW-1:0]   mark_waddr, mark_raddr;
  logic             mark_wdata, mark_rdata;

  logic             accept;
  logic             vok;
  logic             walk_more;
  logic             walk_done;
  logic             found;
  logic             exhaust;
  logic             clr_done;
  logic             out_free;
  logic [VAL_W-1:0] hi_cap;
  logic [VAL_W-1:0] lo_cap;
  logic             nbr_ok;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign vok         = (cmd_i.index != '0) && (32'(cmd_i.index) <= 32'(vc_q));

  assign walk_more = (slot_q < hi_q);
  assign walk_done = !walk_more && !p1_q && !p2_q;
  assign found     = sp_q && !mark_rdata;
  assign exhaust   = sp_q && mark_rdata && (sc_q == RAW'(vc_q));
  assign clr_done  = (clr_q == VAW'(MaxVertices));
  assign out_free  = !ov_q || res_o.ready;

  // edge range clipped to the neighbor store
  assign hi_cap = (32'(row_rdata) > MaxEdges) ? VAL_W'(MaxEdges) : row_rdata;
  assign lo_cap = (lo_q > hi_cap) ? hi_cap : lo_q;

  // skip empty, out-of-range and self-loop neighbors
  assign nbr_ok = (nbr_rdata != '0) && (nbr_rdata <= vc_q) && (nbr_rdata != vtx_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_done) begin
          state_d = init_q ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_COLOR, CMD_CHECK, CMD_READ: state_d = vok ? S_ROW0 : S_RESP;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_ROW0: state_d = S_ROW1;
      S_ROW1: state_d = (cmd_q == CMD_READ) ? S_RESP : S_ROW2;
      S_ROW2: state_d = (cmd_q == CMD_COLOR) ? S_WALK_SET : S_WALK_CHK;
      S_WALK_SET: begin
        if (walk_done) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (found || exhaust) begin
          state_d = S_WALK_CLR;
        end
      end
      S_WALK_CLR, S_WALK_CHK: begin
        if (walk_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    init_d     = init_q;
    ov_d       = ov_q && !res_o.ready;
    p1_d       = 1'b0;
    p2_d       = 1'b0;
    sp_d       = sp_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    vtx_d      = vtx_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    slot_d     = slot_q;
    cv_d       = cv_q;
    res_col_d  = res_col_q;
    conf_d     = conf_q;
    srch_d     = srch_q;
    sc_d       = sc_q;
    out_col_d  = out_col_q;
    out_conf_d = out_conf_q;

    row_we     = 1'b0;
    row_waddr  = RAW'(cmd_i.index);
    row_wdata  = cmd_i.value;
    row_raddr  = '0;
    nbr_we     = 1'b0;
    nbr_waddr  = EAW'(cmd_i.index);
    nbr_wdata  = (32'(cmd_i.value) <= MaxVertices) ? VAW'(cmd_i.value) : '0;
    nbr_raddr  = '0;
    col_we     = 1'b0;
    col_waddr  = clr_q;
    col_wdata  = '0;
    col_raddr  = '0;
    mark_we    = 1'b0;
    mark_waddr = clr_q;
    mark_wdata = 1'b0;
    mark_raddr = '0;

    case (state_q)
      S_CLEAR: begin
        col_we  = 1'b1;
        mark_we = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_done) begin
          init_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_i.command;
          vtx_d     = VAW'(cmd_i.index);
          res_col_d = '0;
          conf_d    = 1'b0;
          clr_d     = '0;
          row_we    = (cmd_i.command == CMD_ROW_START) &&
                      (32'(cmd_i.index) < MaxVertices + 2);
          nbr_we    = (cmd_i.command == CMD_NEIGHBOR) &&
                      (32'(cmd_i.index) < MaxEdges);
        end
      end
      S_ROW0: begin
        row_raddr = RAW'(vtx_q);
        col_raddr = vtx_q;
      end
      S_ROW1: begin
        lo_d      = row_rdata;
        cv_d      = col_rdata;
        res_col_d = col_rdata;
        row_raddr = RAW'(vtx_q) + 1'b1;
      end
      S_ROW2: begin
        hi_d   = hi_cap;
        lo_d   = lo_cap;
        slot_d = lo_cap;
      end
      S_WALK_SET, S_WALK_CLR, S_WALK_CHK: begin
        // slot read, neighbor color read, mark update or compare
        if (walk_more) begin
          nbr_raddr = EAW'(slot_q);
          p1_d      = 1'b1;
          slot_d    = slot_q + 1'b1;
        end
        if (p1_q && nbr_ok) begin
          col_raddr = nbr_rdata;
          p2_d      = 1'b1;
        end
        if (p2_q) begin
          if (state_q == S_WALK_CHK) begin
            if ((cv_q != '0) && (col_rdata == cv_q)) begin
              conf_d = 1'b1;
            end
          end else begin
            mark_we    = (col_rdata != '0);
            mark_waddr = col_rdata;
            mark_wdata = (state_q == S_WALK_SET);
          end
        end
        if ((state_q == S_WALK_SET) && walk_done) begin
          srch_d = RAW'(1);
          sp_d   = 1'b0;
        end
      end
      S_SEARCH: begin
        col_waddr = vtx_q;
        col_wdata = found ? VAW'(sc_q) : '0;
        if (found || exhaust) begin
          col_we    = 1'b1;
          res_col_d = col_wdata;
          slot_d    = lo_q;
          sp_d      = 1'b0;
        end else if (srch_q <= RAW'(vc_q)) begin
          mark_raddr = VAW'(srch_q);
          sp_d       = 1'b1;
          sc_d       = srch_q;
          srch_d     = srch_q + 1'b1;
        end else begin
          sp_d = 1'b0;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_d       = 1'b1;
          out_col_d  = COLOR_W'(res_col_q);
          out_conf_d = conf_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      init_q  <= 1'b1;
      ov_q    <= 1'b0;
      vc_q    <= VAW'(1);
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      sp_q    <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      ov_q    <= ov_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      sp_q    <= sp_d;
      clr_q   <= clr_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.data == '0) begin
          vc_q <= VAW'(1);
        end else if (32'(cfg_i.data) > MaxVertices) begin
          vc_q <= VAW'(MaxVertices);
        end else begin
          vc_q <= VAW'(cfg_i.data);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    vtx_q      <= vtx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    slot_q     <= slot_d;
    cv_q       <= cv_d;
    res_col_q  <= res_col_d;
    conf_q     <= conf_d;
    srch_q     <= srch_d;
    sc_q       <= sc_d;
    out_col_q  <= out_col_d;
    out_conf_q <= out_conf_d;
  end

  assign res_o.valid    = ov_q;
  assign res_o.color    = out_col_q;
  assign res_o.conflict = out_conf_q;

  ggc_ram #(.Width(VAL_W), .Depth(MaxVertices + 2)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  ggc_ram #(.Width(VAW), .Depth(MaxEdges)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (nbr_wdata),
    .raddr_i (nbr_raddr),
    .rdata_o (nbr_rdata)
  );

  ggc_ram #(.Width(VAW), .Depth(MaxVertices + 1)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  ggc_ram #(.Width(1), .Depth(MaxVertices + 1)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

endmodule

// ===== rtl/ggc_ram.sv =====
// ----------------------------------------------------------------------------
// ggc_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ggc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/greedy_graph_coloring_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_graph_coloring_tb
// loads small graphs in compressed row form, colors and checks their vertices
// under several vertex counts, and compares every result with a local
// first-fit predictor while both channels idle and stall at random
// ----------------------------------------------------------------------------
module greedy_graph_coloring_tb;
  import ggc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int unsigned ROW_DEPTH      = MAX_VERTICES + 2;
  localparam int unsigned IDX_MAX        = (1 << IDX_W) - 1;
  localparam int unsigned VAL_MAX        = (1 << VAL_W) - 1;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RAND_PER_PHASE = 45;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               conflict;
  } result_t;

  logic clk;
  logic rst_n;

  ggc_cfg_if cfg_ch ();
  ggc_cmd_if cmd_ch ();
  ggc_res_if res_ch ();

  greedy_graph_coloring uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  // predicted block state
  logic [IDX_W-1:0]   row_mem   [ROW_DEPTH];
  logic [COLOR_W-1:0] nbr_mem   [MAX_EDGES];
  logic [COLOR_W-1:0] color_mem [MAX_VERTICES+1];
  bit                 used_mark [MAX_VERTICES+1];
  int unsigned        live_vertices;

  // what the stimulus has loaded so far, to keep walks on written entries
  int unsigned gen_row      [ROW_DEPTH];
  bit          gen_row_set  [ROW_DEPTH];
  bit          gen_slot_set [MAX_EDGES];
  int unsigned gen_vcnt;

  cmd_item_t pending_cmds [$];
  result_t   expected_results [$];
  cmd_item_t offer;
  result_t   want;
  bit        offering, cmd_taken, res_taken;
  int unsigned send_gap, recv_stall, sender_quiet, recv_quiet;
  bit        hold_arm, hold_done;
  int unsigned hold_left;
  int unsigned n_items, n_results, n_errors, n_settings, n_clashes, n_colored, n_clears;

  // ---------------------------------------------------------------- predictor

  function automatic void slot_span(input int unsigned v, output int unsigned lo,
                                    output int unsigned hi);
    hi = row_mem[v+1];
    if (hi > MAX_EDGES) hi = MAX_EDGES;
    lo = row_mem[v];
    if (lo > hi) lo = hi;
  endfunction

  // neighbor in slot s, 0 when the walk skips it
  function automatic int unsigned neighbor_of(input int unsigned s, input int unsigned v);
    int unsigned w;
    w = nbr_mem[s];
    if (w == 0 || w > live_vertices || w == v) return 0;
    return w;
  endfunction

  function automatic void mark_colors(input int unsigned v, input bit flag);
    int unsigned lo, hi, s, w;
    slot_span(v, lo, hi);
    for (s = lo; s < hi; s++) begin
      w = neighbor_of(s, v);
      if (w != 0 && color_mem[w] != 0) used_mark[color_mem[w]] = flag;
    end
  endfunction

  function automatic logic [COLOR_W-1:0] first_fit(input int unsigned v);
    logic [COLOR_W-1:0] pick;
    int unsigned c;
    pick = '0;
    color_mem[v] = '0;
    mark_colors(v, 1'b1);
    for (c = 1; c <= live_vertices; c++) begin
      if (!used_mark[c]) begin
        pick = c[COLOR_W-1:0];
        break;
      end
    end
    mark_colors(v, 1'b0);
    color_mem[v] = pick;
    return pick;
  endfunction

  function automatic logic clashes(input int unsigned v);
    int unsigned lo, hi, s, w;
    if (color_mem[v] == 0) return 1'b0;
    slot_span(v, lo, hi);
    for (s = lo; s < hi; s++) begin
      w = neighbor_of(s, v);
      if (w != 0 && color_mem[w] == color_mem[v]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_coloring(input cmd_item_t it);
    result_t r;
    int unsigned v;
    bit in_range;
    r = '0;
    v = it.index;
    in_range = (v >= 1) && (v <= live_vertices);
    case (it.command)
      CMD_ROW_START: begin
        if (v < ROW_DEPTH) row_mem[v] = it.value;
      end
      CMD_NEIGHBOR: begin
        if (v < MAX_EDGES) nbr_mem[v] = (it.value <= MAX_VERTICES) ? it.value[COLOR_W-1:0] : '0;
      end
      CMD_CLEAR: begin
        foreach (color_mem[i]) color_mem[i] = '0;
        n_clears++;
      end
      CMD_COLOR: begin
        if (in_range) r.color = first_fit(v);
        if (r.color != 0) n_colored++;
      end
      CMD_CHECK: begin
        if (in_range) begin
          r.color    = color_mem[v];
          r.conflict = clashes(v);
        end
      end
      CMD_READ: begin
        if (in_range) r.color = color_mem[v];
      end
      default: ;
    endcase
    return r;
  endfunction

  // ----------------------------------------------------------------- stimulus

  function automatic bit walk_safe(input int unsigned v);
    int unsigned lo, hi, s;
    if (v < 1 || v > gen_vcnt) return 1'b1;
    if (!gen_row_set[v] || !gen_row_set[v+1]) return 1'b0;
    hi = (gen_row[v+1] > MAX_EDGES) ? MAX_EDGES : gen_row[v+1];
    lo = (gen_row[v] > hi) ? hi : gen_row[v];
    for (s = lo; s < hi; s++) begin
      if (!gen_slot_set[s]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // a color or check that would walk unloaded entries becomes a read
  function automatic void queue_item(input logic [CMD_W-1:0] command, input int unsigned index,
                                     input int unsigned value);
    cmd_item_t it;
    if ((command == CMD_COLOR || command == CMD_CHECK) && !walk_safe(index)) command = CMD_READ;
    it.command = command;
    it.index   = index[IDX_W-1:0];
    it.value   = value[VAL_W-1:0];
    if (command == CMD_ROW_START && index < ROW_DEPTH) begin
      gen_row[index]     = value;
      gen_row_set[index] = 1'b1;
    end
    if (command == CMD_NEIGHBOR && index < MAX_EDGES) gen_slot_set[index] = 1'b1;
    pending_cmds.push_back(it);
  endfunction

  function automatic int unsigned pick_neighbor(input int unsigned v, input int unsigned nv);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return v;
    if (r == 2) return $urandom_range(MAX_VERTICES + 1, VAL_MAX);
    if (r == 3) return $urandom_range(1, MAX_VERTICES);
    return $urandom_range(1, nv);
  endfunction

  function automatic int unsigned pick_vertex(input int unsigned nv);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return gen_vcnt;
    if (r == 2) return gen_vcnt + 1;
    if (r == 3) return $urandom_range(0, IDX_MAX);
    return $urandom_range(1, nv);
  endfunction

  function automatic void load_graph(input int unsigned nv, input int unsigned base,
                                     output int unsigned used);
    int unsigned v, k, deg, slot;
    slot = base;
    for (v = 1; v <= nv; v++) begin
      queue_item(CMD_ROW_START, v, slot);
      deg = $urandom_range(0, 4);
      for (k = 0; k < deg; k++) begin
        queue_item(CMD_NEIGHBOR, slot, pick_neighbor(v, nv));
        slot++;
      end
    end
    queue_item(CMD_ROW_START, nv + 1, slot);
    used = slot - base;
  endfunction

  function automatic void random_item(input int unsigned nv, input int unsigned base,
                                      input int unsigned used);
    int unsigned r, idx, val;
    r = $urandom_range(0, 99);
    val = $urandom_range(0, VAL_MAX);
    if (r < 35) begin
      queue_item(CMD_COLOR, pick_vertex(nv), val);
    end else if (r < 55) begin
      queue_item(CMD_CHECK, pick_vertex(nv), val);
    end else if (r < 68) begin
      queue_item(CMD_READ, pick_vertex(nv), val);
    end else if (r < 78) begin
      idx = ($urandom_range(0, 9) != 0) ? base + $urandom_range(0, used) : $urandom_range(0, IDX_MAX);
      queue_item(CMD_NEIGHBOR, idx, pick_neighbor($urandom_range(1, nv), nv));
    end else if (r < 83) begin
      idx = ($urandom_range(0, 9) != 0) ? $urandom_range(1, nv + 1) : $urandom_range(0, IDX_MAX);
      if ($urandom_range(0, 9) != 0) val = base + $urandom_range(0, used);
      queue_item(CMD_ROW_START, idx, val);
    end else if (r < 85) begin
      queue_item(CMD_CLEAR, $urandom_range(0, IDX_MAX), val);
    end else if (r < 87) begin
      queue_item(($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7,
                 $urandom_range(0, IDX_MAX), val);
    end else begin
      queue_item(CMD_READ, $urandom_range(0, IDX_MAX), val);
    end
  endfunction

  // ------------------------------------------------------------------ helpers

  function automatic int unsigned draw_wait(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic set_vertex_count(input int unsigned setting);
    int unsigned eff;
    eff = setting % (1 << CFG_W);
    if (eff == 0) eff = 1;
    if (eff > MAX_VERTICES) eff = MAX_VERTICES;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= setting[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    live_vertices = eff;
    gen_vcnt      = eff;
    n_settings++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || offering || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new count, fresh graph, color in order, check all, then random traffic
  task automatic run_phase(input int unsigned setting);
    int unsigned nv, base, used, v;
    set_vertex_count(setting);
    nv   = $urandom_range(3, 16);
    base = $urandom_range(0, MAX_EDGES - 200);
    load_graph(nv, base, used);
    for (v = 1; v <= nv; v++) queue_item(CMD_COLOR, v, $urandom_range(0, VAL_MAX));
    for (v = 1; v <= nv; v++) queue_item(CMD_CHECK, v, $urandom_range(0, VAL_MAX));
    repeat (RAND_PER_PHASE) random_item(nv, base, used);
  endtask

  // ---------------------------------------------------------- clock and limit

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("FAILED: results differ");
    $finish;
  end

  // ------------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (cmd_ch.valid && cmd_ch.ready) begin
      expected_results.push_back(predict_coloring(offer));
      cmd_taken = 1'b1;
      n_items++;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        offering  = 1'b0;
        send_gap  = draw_wait(sender_quiet);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          offer    = pending_cmds.pop_front();
          offering = 1'b1;
        end
      end
      cmd_ch.valid <= offering;
      if (offering) begin
        cmd_ch.command <= offer.command;
        cmd_ch.index   <= offer.index;
        cmd_ch.value   <= offer.value;
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  // long receiver hold-off, started once on request
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (res_taken) begin
        res_taken  = 1'b0;
        recv_stall = draw_wait(recv_quiet);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      res_ch.ready <= (recv_stall == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) begin
      res_taken = 1'b1;
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: color %0d conflict %0b",
                 $time, res_ch.color, res_ch.conflict);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.color !== want.color) begin
          $display("%0t: color mismatch: expected %0d, actual %0d",
                   $time, want.color, res_ch.color);
          n_errors++;
        end
        if (res_ch.conflict !== want.conflict) begin
          $display("%0t: conflict mismatch: expected %0b, actual %0b",
                   $time, want.conflict, res_ch.conflict);
          n_errors++;
        end
        if (want.conflict) n_clashes++;
      end
    end
  end

  // ----------------------------------------------------------------- sequence

  initial begin
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.index   = '0;
    cmd_ch.value   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    res_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    foreach (color_mem[i]) color_mem[i] = '0;
    foreach (used_mark[i]) used_mark[i] = 1'b0;
    foreach (row_mem[i]) row_mem[i] = '0;
    foreach (nbr_mem[i]) nbr_mem[i] = '0;
    live_vertices = 1;
    gen_vcnt      = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset vertex count of one: out of range vertices, spare commands,
    // ignored loads, self loop, clear and recolor
    queue_item(CMD_READ, 0, 0);
    queue_item(CMD_READ, IDX_MAX, VAL_MAX);
    queue_item(CMD_COLOR, 2, 0);
    queue_item(CMD_CHECK, 0, 0);
    queue_item(CMD_SPARE6, IDX_MAX, VAL_MAX);
    queue_item(CMD_SPARE7, 0, 0);
    queue_item(CMD_ROW_START, 1, 0);
    queue_item(CMD_ROW_START, 2, 2);
    queue_item(CMD_NEIGHBOR, 0, 1);
    queue_item(CMD_NEIGHBOR, 1, VAL_MAX);
    queue_item(CMD_ROW_START, ROW_DEPTH, 5);
    queue_item(CMD_ROW_START, IDX_MAX, VAL_MAX);
    queue_item(CMD_NEIGHBOR, MAX_EDGES, 3);
    queue_item(CMD_NEIGHBOR, IDX_MAX, 0);
    queue_item(CMD_COLOR, 1, 0);
    queue_item(CMD_CHECK, 1, VAL_MAX);
    queue_item(CMD_READ, 1, 0);
    queue_item(CMD_CLEAR, 0, 0);
    queue_item(CMD_READ, 1, 0);
    queue_item(CMD_CHECK, 1, 0);
    queue_item(CMD_COLOR, 1, 0);
    drain();

    run_phase(0);
    drain();
    run_phase((1 << CFG_W) - 1);
    drain();

    // edge range clipped at the end of the neighbor store, and empty ranges
    run_phase(40);
    queue_item(CMD_ROW_START, 30, MAX_EDGES - 2);
    queue_item(CMD_ROW_START, 31, VAL_MAX);
    queue_item(CMD_ROW_START, 32, 9000);
    queue_item(CMD_ROW_START, 33, 100);
    queue_item(CMD_NEIGHBOR, MAX_EDGES - 2, 1);
    queue_item(CMD_NEIGHBOR, MAX_EDGES - 1, 30);
    queue_item(CMD_COLOR, 30, 0);
    queue_item(CMD_CHECK, 30, 0);
    queue_item(CMD_COLOR, 31, 0);
    queue_item(CMD_COLOR, 32, 0);
    queue_item(CMD_CHECK, 32, 0);
    drain();

    // top vertex, neighbor equal to the vertex limit and just above it
    run_phase(MAX_VERTICES);
    queue_item(CMD_ROW_START, MAX_VERTICES, MAX_EDGES - 8);
    queue_item(CMD_ROW_START, MAX_VERTICES + 1, MAX_EDGES - 5);
    queue_item(CMD_NEIGHBOR, MAX_EDGES - 8, MAX_VERTICES);
    queue_item(CMD_NEIGHBOR, MAX_EDGES - 7, 1);
    queue_item(CMD_NEIGHBOR, MAX_EDGES - 6, MAX_VERTICES + 1);
    queue_item(CMD_COLOR, MAX_VERTICES, 0);
    queue_item(CMD_CHECK, MAX_VERTICES, 0);
    queue_item(CMD_READ, MAX_VERTICES, 0);
    queue_item(CMD_COLOR, 1, 0);
    queue_item(CMD_CHECK, MAX_VERTICES, 0);
    drain();

    run_phase(MAX_VERTICES + 1);
    drain();
    run_phase(5);
    drain();
    run_phase(2);
    drain();
    // receiver hold-off is started once this phase is queued
    run_phase(300);
    hold_arm = 1'b1;
    drain();
    run_phase(1);
    drain();
    run_phase($urandom_range(3, (1 << CFG_W) - 1));
    drain();

    $display("covered %0d commands and %0d results over %0d vertex count settings",
             n_items, n_results, n_settings);
    $display("%0d vertices colored, %0d conflicts flagged, %0d color clears",
             n_colored, n_clashes, n_clears);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
